@@ rtl/ppwr_pkg.sv @@
// ----------------------------------------------------------------------------
// ppwr_pkg
// Types and constants shared by the peak pyramid window reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ppwr_pkg;

  // Pyramid geometry.
  localparam int unsigned MAX_BASE_BUCKETS = 1024;
  localparam int unsigned CHANNELS         = 2;
  localparam int unsigned MAX_PIXELS       = 32;
  localparam int unsigned CNT_W            = $clog2(MAX_BASE_BUCKETS + 1);
  localparam int unsigned OFF_W            = $clog2(2 * MAX_BASE_BUCKETS);
  localparam int unsigned CH_W             = $clog2(CHANNELS);
  localparam int unsigned ADDR_W           = CH_W + OFF_W;
  localparam int unsigned STORE_DEPTH      = CHANNELS * 2 * MAX_BASE_BUCKETS;
  localparam int unsigned STORE_W          = 32;

  // Divider geometry: dividend holds end + span - 1.
  localparam int unsigned DIVIDEND_W = 34;
  localparam int unsigned DIVISOR_W  = 32;

  // Item modes.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic REG_BASE_FRAMES = 1'b0;
  localparam logic REG_DOC_FRAMES  = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic               channel;
    logic signed [15:0] bucket_min;
    logic signed [15:0] bucket_max;
    logic               channel_done;
    logic [31:0]        query_start;
    logic [31:0]        query_count;
    logic [5:0]         disp_width;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] peak_min;
    logic signed [15:0] peak_max;
    logic [31:0]        window_start;
    logic [31:0]        span_frames;
    logic               empty_res;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/peak_pyramid_window_reader_core.sv @@
// ----------------------------------------------------------------------------
// peak_pyramid_window_reader_core
// Min/max waveform pyramid per channel, built in a RAM, with window queries.
//
// Channel    Signals                               Handshake
// item in    in_item_i                             start & !busy
// result     res_item_o                            res_strobe_o, one cycle
// config     psel penable pwrite paddr pwdata      APB write, pready always 1
//
// A load is written as it is accepted; closing a channel then builds the
// upper levels, each merged bucket through the states B_RA, B_RB and B_WR.
// A query runs two 34-step divisions and a compare for each pyramid level
// it examines, clamps to the level, then reads each result through the
// states RD and OUT (registered RAM read). Reset clears the counts, ready
// flags and error flag; the RAM contents need no clearing. Results cannot
// be stalled; busy is high while a build or query is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_pyramid_window_reader_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire ppwr_pkg::in_item_t   in_item_i,
  output      logic                 res_strobe_o,
  output      ppwr_pkg::out_item_t  res_item_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output      logic [31:0]          prdata,
  output      logic                 pready
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_B_RA  = 13'b0000000000010,
    ST_B_RB  = 13'b0000000000100,
    ST_B_WR  = 13'b0000000001000,
    ST_D1S   = 13'b0000000010000,
    ST_D1W   = 13'b0000000100000,
    ST_D2S   = 13'b0000001000000,
    ST_D2W   = 13'b0000010000000,
    ST_CHK   = 13'b0000100000000,
    ST_FIN   = 13'b0001000000000,
    ST_EMPTY = 13'b0010000000000,
    ST_RD    = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } state_e;

  localparam int unsigned CW = ppwr_pkg::CNT_W;
  localparam int unsigned OW = ppwr_pkg::OFF_W;
  localparam int unsigned DW = ppwr_pkg::DIVIDEND_W;

  state_e                        state_q, state_d;
  logic [31:0]                   base_frames_q, doc_frames_q;
  logic [CW-1:0]                 count_q [ppwr_pkg::CHANNELS];
  logic [CW-1:0]                 count_d [ppwr_pkg::CHANNELS];
  logic [ppwr_pkg::CHANNELS-1:0] ready_q, ready_d;
  logic                          bad_q, bad_d;

  // Working registers shared by build and query.
  logic [ppwr_pkg::CH_W-1:0]     ch_q, ch_d;
  logic [OW-1:0]                 off_q, off_d;
  logic [CW-1:0]                 size_q, size_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 lim_q, lim_d;
  logic                          pair_q, pair_d;
  logic [31:0]                   word_q, word_d;
  logic [31:0]                   qstart_q, qstart_d;
  logic [31:0]                   qend_q, qend_d;
  logic [6:0]                    target_q, target_d;
  logic [31:0]                   span_q, span_d;
  logic [DW-1:0]                 first_q, first_d;
  logic [DW-1:0]                 lastb_q, lastb_d;
  logic [31:0]                   ws_q, ws_d;
  logic                          valid_q, valid_d;
  ppwr_pkg::out_item_t           out_q, out_d;

  // RAM and divider connections.
  logic                          we;
  logic [ppwr_pkg::ADDR_W-1:0]   waddr, raddr;
  logic [31:0]                   wdata, rdata;
  logic                          div_go, div_done;
  logic [DW-1:0]                 div_dividend, div_quot;

  // Helper values.
  logic                          accept;
  logic                          cfg_wr;
  logic [CW-1:0]                 cnt_in, cnt_new;
  logic                          fits;
  logic                          q_ok;
  logic [5:0]                    px;
  logic [31:0]                   q_end;
  logic [CW:0]                   half;
  logic [DW-1:0]                 diff;
  logic [CW-1:0]                 fc, lc;
  logic [42:0]                   prod;
  logic signed [15:0]            a_min, a_max, b_min, b_max;
  logic [31:0]                   merged;
  logic [CW-1:0]                 idx_next;

  ppwr_ram #(
    .WIDTH (ppwr_pkg::STORE_W),
    .DEPTH (ppwr_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ppwr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (div_dividend),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == ppwr_pkg::REG_DOC_FRAMES) ? doc_frames_q : base_frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_frames_q <= '0;
      doc_frames_q  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == ppwr_pkg::REG_BASE_FRAMES) begin
        base_frames_q <= pwdata;
      end else begin
        doc_frames_q <= pwdata;
      end
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign accept = start & ~busy;

  // Query validity and window bounds at acceptance.
  always_comb begin
    q_ok = (base_frames_q != '0) && (doc_frames_q != '0) && !bad_q
           && (in_item_i.query_count != '0) && (in_item_i.disp_width != '0)
           && (in_item_i.query_start < doc_frames_q);
    for (int c = 0; c < ppwr_pkg::CHANNELS; c++) begin
      if (!ready_q[c] || count_q[c] == '0) begin
        q_ok = 1'b0;
      end
    end
    px = (in_item_i.disp_width > 6'(ppwr_pkg::MAX_PIXELS))
         ? 6'(ppwr_pkg::MAX_PIXELS) : in_item_i.disp_width;
    q_end = (in_item_i.query_count > doc_frames_q - in_item_i.query_start)
            ? doc_frames_q : in_item_i.query_start + in_item_i.query_count;
  end

  // Merge of two stored buckets.
  always_comb begin
    a_min  = word_q[15:0];
    a_max  = word_q[31:16];
    b_min  = rdata[15:0];
    b_max  = rdata[31:16];
    merged = {(a_max > b_max) ? a_max : b_max, (a_min < b_min) ? a_min : b_min};
  end

  // Main sequencer.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ready_d  = ready_q;
    bad_d    = bad_q;
    ch_d     = ch_q;
    off_d    = off_q;
    size_d   = size_q;
    idx_d    = idx_q;
    lim_d    = lim_q;
    pair_d   = pair_q;
    word_d   = word_q;
    qstart_d = qstart_q;
    qend_d   = qend_q;
    target_d = target_q;
    span_d   = span_q;
    first_d  = first_q;
    lastb_d  = lastb_q;
    ws_d     = ws_q;
    valid_d  = 1'b0;
    out_d    = out_q;
    we       = 1'b0;
    waddr    = {ch_q, OW'(off_q + OW'(size_q) + OW'(idx_q >> 1))};
    wdata    = pair_q ? merged : word_q;
    raddr    = {ch_q, OW'(off_q + OW'(idx_q))};
    div_go   = 1'b0;
    div_dividend = {2'b00, qstart_q};
    cnt_in   = count_q[in_item_i.channel];
    fits     = (cnt_in < CW'(ppwr_pkg::MAX_BASE_BUCKETS));
    cnt_new  = fits ? cnt_in + CW'(1) : cnt_in;
    half     = ({1'b0, size_q} + (CW+1)'(1)) >> 1;
    diff     = lastb_q - first_q;
    fc       = (first_q > DW'(size_q)) ? size_q : first_q[CW-1:0];
    lc       = (lastb_q > DW'(size_q)) ? size_q : lastb_q[CW-1:0];
    prod     = 43'(fc) * 43'(span_q);
    idx_next = idx_q + CW'(1);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.mode)
            ppwr_pkg::MODE_CLEAR: begin
              for (int c = 0; c < ppwr_pkg::CHANNELS; c++) begin
                count_d[c] = '0;
              end
              ready_d = '0;
              bad_d   = 1'b0;
            end
            ppwr_pkg::MODE_LOAD: begin
              if (!ready_q[in_item_i.channel]) begin
                if (in_item_i.bucket_min > in_item_i.bucket_max) begin
                  bad_d = 1'b1;
                end
                if (fits) begin
                  we    = 1'b1;
                  waddr = {in_item_i.channel, OW'(cnt_in)};
                  wdata = {in_item_i.bucket_max, in_item_i.bucket_min};
                end
                count_d[in_item_i.channel] = cnt_new;
                if (in_item_i.channel_done) begin
                  ready_d[in_item_i.channel] = 1'b1;
                  ch_d   = in_item_i.channel;
                  off_d  = '0;
                  size_d = cnt_new;
                  idx_d  = '0;
                  if (cnt_new > CW'(1)) begin
                    state_d = ST_B_RA;
                  end
                end
              end
            end
            ppwr_pkg::MODE_QUERY: begin
              if (!q_ok) begin
                valid_d = 1'b1;
                out_d   = '0;
                out_d.empty_res = 1'b1;
                out_d.last      = 1'b1;
              end else begin
                ch_d     = in_item_i.channel;
                off_d    = '0;
                size_d   = count_q[in_item_i.channel];
                qstart_d = in_item_i.query_start;
                qend_d   = q_end;
                target_d = {px, 1'b0};
                span_d   = base_frames_q;
                state_d  = ST_D1S;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Build: read first bucket of the pair.
      ST_B_RA: begin
        state_d = ST_B_RB;
      end

      // Build: capture first bucket, read the second if there is one.
      ST_B_RB: begin
        word_d  = rdata;
        pair_d  = (idx_next < size_q);
        raddr   = {ch_q, OW'(off_q + OW'(idx_next))};
        state_d = ST_B_WR;
      end

      // Build: write the merged bucket and step the pair or level.
      ST_B_WR: begin
        we = 1'b1;
        if (idx_q + CW'(2) >= size_q) begin
          off_d  = off_q + OW'(size_q);
          size_d = half[CW-1:0];
          idx_d  = '0;
          if (half[CW-1:0] > CW'(1)) begin
            state_d = ST_B_RA;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          idx_d   = idx_q + CW'(2);
          state_d = ST_B_RA;
        end
      end

      // Query: first bucket = start / span.
      ST_D1S: begin
        div_go  = 1'b1;
        state_d = ST_D1W;
      end

      ST_D1W: begin
        if (div_done) begin
          first_d = div_quot;
          state_d = ST_D2S;
        end
      end

      // Query: end bucket = ceil(end / span).
      ST_D2S: begin
        div_go       = 1'b1;
        div_dividend = DW'(qend_q) + DW'(span_q) - DW'(1);
        state_d      = ST_D2W;
      end

      ST_D2W: begin
        if (div_done) begin
          lastb_d = div_quot;
          state_d = ST_CHK;
        end
      end

      // Query: climb a level while the window is too wide.
      ST_CHK: begin
        if (size_q > CW'(1) && diff > DW'(target_q)) begin
          off_d   = off_q + OW'(size_q);
          size_d  = half[CW-1:0];
          span_d  = span_q[31] ? '1 : {span_q[30:0], 1'b0};
          state_d = ST_D1S;
        end else begin
          state_d = ST_FIN;
        end
      end

      // Query: clamp to the level and form the window start.
      ST_FIN: begin
        ws_d  = (prod[42:32] != '0) ? '1 : prod[31:0];
        idx_d = fc;
        lim_d = lc;
        state_d = (lc == fc) ? ST_EMPTY : ST_RD;
      end

      ST_EMPTY: begin
        valid_d            = 1'b1;
        out_d              = '0;
        out_d.window_start = ws_q;
        out_d.span_frames  = span_q;
        out_d.empty_res    = 1'b1;
        out_d.last         = 1'b1;
        state_d            = ST_IDLE;
      end

      ST_RD: begin
        state_d = ST_OUT;
      end

      // Query: emit one bucket.
      ST_OUT: begin
        valid_d            = 1'b1;
        out_d.peak_min     = rdata[15:0];
        out_d.peak_max     = rdata[31:16];
        out_d.window_start = ws_q;
        out_d.span_frames  = span_q;
        out_d.empty_res    = 1'b0;
        out_d.last         = (idx_next == lim_q);
        idx_d              = idx_next;
        state_d            = (idx_next == lim_q) ? ST_IDLE : ST_RD;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int c = 0; c < ppwr_pkg::CHANNELS; c++) begin
        count_q[c] <= '0;
      end
      ready_q <= '0;
      bad_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ready_q <= ready_d;
      bad_q   <= bad_d;
      valid_q <= valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    off_q    <= off_d;
    size_q   <= size_d;
    idx_q    <= idx_d;
    lim_q    <= lim_d;
    pair_q   <= pair_d;
    word_q   <= word_d;
    qstart_q <= qstart_d;
    qend_q   <= qend_d;
    target_q <= target_d;
    span_q   <= span_d;
    first_q  <= first_d;
    lastb_q  <= lastb_d;
    ws_q     <= ws_d;
    out_q    <= out_d;
  end

  assign res_strobe_o = valid_q;
  assign res_item_o   = out_q;

endmodule

`default_nettype wire

@@ rtl/ppwr_ram.sv @@
// ----------------------------------------------------------------------------
// ppwr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ppwr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/ppwr_div.sv @@
// ----------------------------------------------------------------------------
// ppwr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppwr_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              go_i,
  input  wire logic [ppwr_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [ppwr_pkg::DIVISOR_W-1:0]    divisor_i,
  output      logic                              done_o,
  output      logic [ppwr_pkg::DIVIDEND_W-1:0]   quotient_o
);

  localparam int unsigned CNT_BITS = $clog2(ppwr_pkg::DIVIDEND_W + 1);

  logic [CNT_BITS-1:0]               cnt_q, cnt_d;
  logic                              done_q, done_d;
  logic [ppwr_pkg::DIVISOR_W-1:0]    rem_q, rem_d;
  logic [ppwr_pkg::DIVISOR_W-1:0]    dvs_q, dvs_d;
  logic [ppwr_pkg::DIVIDEND_W-1:0]   quo_q, quo_d;
  logic [ppwr_pkg::DIVISOR_W:0]      shifted;
  logic [ppwr_pkg::DIVISOR_W:0]      diff;

  // One shift-and-subtract step per cycle.
  always_comb begin
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    shifted = {rem_q, quo_q[ppwr_pkg::DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (go_i) begin
      cnt_d = CNT_BITS'(ppwr_pkg::DIVIDEND_W);
      rem_d = '0;
      dvs_d = divisor_i;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[ppwr_pkg::DIVISOR_W-1:0];
        quo_d = {quo_q[ppwr_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[ppwr_pkg::DIVISOR_W-1:0];
        quo_d = {quo_q[ppwr_pkg::DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_BITS'(1);
      done_d = (cnt_q == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ dv/peak_pyramid_window_reader_core_tb.sv @@
// ----------------------------------------------------------------------------
// peak_pyramid_window_reader_core_tb
// Self-checking bench for the min/max peak pyramid reader. Items are fed
// through the start/busy handshake. Each result is checked field by field
// against a pyramid model kept in the bench. The APB registers are set to
// several values between phases, extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_pyramid_window_reader_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppwr_pkg::*;

  localparam int unsigned REGION    = 2 * MAX_BASE_BUCKETS;
  localparam int unsigned STALL_MAX = 20000;
  localparam logic [1:0]  MODE_NONE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item_i = '0;
  logic res_strobe_o;
  out_item_t res_item_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  peak_pyramid_window_reader_core uut (
    .clk_i, .rst_ni, .start, .busy, .in_item_i, .res_strobe_o, .res_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pyramid model state.
  logic [31:0] pyr_store [STORE_DEPTH];
  int unsigned bucket_cnt [CHANNELS];
  bit          chan_ready [CHANNELS];
  bit          pyr_bad;
  logic [31:0] base_frames_r, doc_frames_r;

  out_item_t   peak_results_q[$];
  int unsigned errors, n_items, n_results, n_queries, stall_cnt;
  bit          gaps_on = 1'b1;

  function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b);
    if (a == 0 || b == 0) return 0;
    if (a > 64'hFFFF_FFFF / b) return 64'hFFFF_FFFF;
    return a * b;
  endfunction

  function automatic logic [31:0] merge_buckets(logic [31:0] a, logic [31:0] b);
    logic signed [15:0] amin, amax, bmin, bmax;
    amin = a[15:0]; amax = a[31:16]; bmin = b[15:0]; bmax = b[31:16];
    return {(amax > bmax) ? amax : bmax, (amin < bmin) ? amin : bmin};
  endfunction

  // Builds the upper levels of one channel once its base level is closed.
  function automatic void build_pyramid(int unsigned ch);
    int unsigned off, size, nxt, i;
    logic [31:0] w;
    off = 0;
    size = bucket_cnt[ch];
    while (size > 1) begin
      nxt = off + size;
      for (i = 0; i < size; i += 2) begin
        w = pyr_store[ch * REGION + off + i];
        if (i + 1 < size) w = merge_buckets(w, pyr_store[ch * REGION + off + i + 1]);
        pyr_store[ch * REGION + nxt + i / 2] = w;
      end
      off = nxt;
      size = (size + 1) / 2;
    end
  endfunction

  function automatic out_item_t mk_res(logic [31:0] word, longint unsigned ws,
                                       longint unsigned span, bit emp, bit lst);
    out_item_t r;
    r.peak_min = word[15:0];
    r.peak_max = word[31:16];
    r.window_start = ws[31:0];
    r.span_frames = span[31:0];
    r.empty_res = emp;
    r.last = lst;
    return r;
  endfunction

  // Updates the model for one accepted item and queues the peaks it yields.
  function automatic void predict_peaks(in_item_t it);
    int unsigned ch, off, size, c;
    longint unsigned st, cnt, px, doc, bf, end_f, first, lastb, ws;
    bit ok;
    logic signed [15:0] mn, mx;
    ch = it.channel;
    mn = it.bucket_min;
    mx = it.bucket_max;
    case (it.mode)
      MODE_CLEAR: begin
        for (c = 0; c < CHANNELS; c++) begin
          bucket_cnt[c] = 0;
          chan_ready[c] = 1'b0;
        end
        pyr_bad = 1'b0;
      end
      MODE_LOAD: begin
        if (!chan_ready[ch]) begin
          if (mn > mx) pyr_bad = 1'b1;
          if (bucket_cnt[ch] < MAX_BASE_BUCKETS) begin
            pyr_store[ch * REGION + bucket_cnt[ch]] = {mx, mn};
            bucket_cnt[ch]++;
          end
          if (it.channel_done) begin
            chan_ready[ch] = 1'b1;
            build_pyramid(ch);
          end
        end
      end
      MODE_QUERY: begin
        n_queries++;
        st = it.query_start;
        cnt = it.query_count;
        px = it.disp_width;
        doc = doc_frames_r;
        bf = base_frames_r;
        ok = bf != 0 && doc != 0 && !pyr_bad && cnt != 0 && px != 0 && st < doc;
        for (c = 0; c < CHANNELS; c++)
          if (!chan_ready[c] || bucket_cnt[c] == 0) ok = 1'b0;
        if (!ok) begin
          peak_results_q.insert(peak_results_q.size(), mk_res('0, 0, 0, 1'b1, 1'b1));
          return;
        end
        if (px > MAX_PIXELS) px = MAX_PIXELS;
        end_f = (cnt > doc - st) ? doc : st + cnt;
        off = 0;
        size = bucket_cnt[ch];
        // Climb until the window fits in twice the display width.
        while (size > 1) begin
          if ((end_f + bf - 1) / bf - st / bf <= 2 * px) break;
          off += size;
          size = (size + 1) / 2;
          bf = sat_mul(bf, 2);
        end
        first = st / bf;
        lastb = (end_f + bf - 1) / bf;
        if (first > size) first = size;
        if (lastb > size) lastb = size;
        ws = sat_mul(first, bf);
        if (lastb <= first) begin
          peak_results_q.insert(peak_results_q.size(), mk_res('0, ws, bf, 1'b1, 1'b1));
          return;
        end
        for (longint unsigned k = first; k < lastb; k++)
          peak_results_q.insert(peak_results_q.size(),
                                mk_res(pyr_store[ch * REGION + off + k], ws, bf,
                                       1'b0, k == lastb - 1));
      end
      default: ;
    endcase
  endfunction

  // Result checker and stall watchdog.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni) begin
      if (res_strobe_o || (start && !busy)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("%0t: watchdog expired, %0d peaks outstanding", $time,
                 peak_results_q.size());
        $display("Test completed with failures");
        $finish;
      end
      if (res_strobe_o) begin
        n_results++;
        if (peak_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual %p", $time, res_item_o);
        end else begin
          exp_r = peak_results_q.pop_front();
          if (res_item_o.peak_min !== exp_r.peak_min) begin
            errors++;
            $display("%0t: peak_min expected %0d actual %0d", $time,
                     exp_r.peak_min, res_item_o.peak_min);
          end
          if (res_item_o.peak_max !== exp_r.peak_max) begin
            errors++;
            $display("%0t: peak_max expected %0d actual %0d", $time,
                     exp_r.peak_max, res_item_o.peak_max);
          end
          if (res_item_o.window_start !== exp_r.window_start) begin
            errors++;
            $display("%0t: window_start expected %h actual %h", $time,
                     exp_r.window_start, res_item_o.window_start);
          end
          if (res_item_o.span_frames !== exp_r.span_frames) begin
            errors++;
            $display("%0t: span_frames expected %h actual %h", $time,
                     exp_r.span_frames, res_item_o.span_frames);
          end
          if (res_item_o.empty_res !== exp_r.empty_res) begin
            errors++;
            $display("%0t: empty_res expected %b actual %b", $time,
                     exp_r.empty_res, res_item_o.empty_res);
          end
          if (res_item_o.last !== exp_r.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time,
                     exp_r.last, res_item_o.last);
          end
        end
      end
    end
  end

  // Presents one item and returns at the edge that accepts it; start stays high.
  task automatic send_item(in_item_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    start <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (busy);
    n_items++;
    predict_peaks(it);
  endtask

  // Waits for every expected peak and for the block to go quiet.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (peak_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_BASE_FRAMES) base_frames_r = val;
    else doc_frames_r = val;
  endtask

  task automatic set_regs(logic [31:0] bfr, logic [31:0] dfr);
    drain();
    write_reg(REG_BASE_FRAMES, bfr);
    write_reg(REG_DOC_FRAMES, dfr);
  endtask

  function automatic in_item_t op_item(logic [1:0] mode, bit ch);
    in_item_t it;
    it = '0;
    it.mode = mode;
    it.channel = ch;
    return it;
  endfunction

  task automatic load_bucket(bit ch, logic [15:0] mn, logic [15:0] mx, bit done);
    in_item_t it;
    it = op_item(MODE_LOAD, ch);
    it.bucket_min = mn;
    it.bucket_max = mx;
    it.channel_done = done;
    send_item(it);
  endtask

  task automatic query(bit ch, logic [31:0] st, logic [31:0] cnt, logic [5:0] px);
    in_item_t it;
    it = op_item(MODE_QUERY, ch);
    it.query_start = st;
    it.query_count = cnt;
    it.disp_width = px;
    send_item(it);
  endtask

  // Loads n well-formed random buckets into a channel and closes it.
  task automatic load_channel(bit ch, int unsigned n);
    logic signed [15:0] a, b;
    for (int unsigned i = 0; i < n; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      if (a > b) load_bucket(ch, b, a, i == n - 1);
      else load_bucket(ch, a, b, i == n - 1);
    end
  endtask

  // Directed checks: invalid queries, extremes, clamping and error cases.
  task automatic test_directed();
    query(1'b0, 0, 10, 4);
    set_regs(4, 100);
    query(1'b0, 0, 10, 4);
    load_bucket(1'b0, 16'h8000, 16'h7FFF, 1'b0);
    load_bucket(1'b0, 16'h0000, 16'h0001, 1'b0);
    load_bucket(1'b0, 16'hFFFF, 16'h0000, 1'b0);
    load_bucket(1'b0, 16'h8000, 16'h8000, 1'b0);
    load_bucket(1'b0, 16'h7FFF, 16'h7FFF, 1'b1);
    load_bucket(1'b0, 16'h1234, 16'h5678, 1'b1);
    load_bucket(1'b1, 16'hC000, 16'h4000, 1'b0);
    load_bucket(1'b1, 16'h8001, 16'h7FFE, 1'b0);
    load_bucket(1'b1, 16'h0100, 16'h0200, 1'b1);
    query(1'b0, 0, 20, 1);
    query(1'b0, 3, 1, 32);
    query(1'b1, 0, 32'hFFFF_FFFF, 63);
    query(1'b0, 5, 0, 4);
    query(1'b0, 5, 10, 0);
    query(1'b0, 100, 10, 4);
    query(1'b1, 90, 10, 32);
    send_item(op_item(MODE_NONE, 1'b1));
    load_bucket(1'b0, 16'h0005, 16'h0001, 1'b0);
    query(1'b0, 0, 20, 2);
    send_item(op_item(MODE_CLEAR, 1'b0));
    load_bucket(1'b0, 16'h0005, 16'h0001, 1'b1);
    load_bucket(1'b1, 16'h0000, 16'h0000, 1'b1);
    query(1'b1, 0, 8, 2);
  endtask

  // Extreme register values with saturating spans, and a long base level.
  task automatic test_extremes();
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(op_item(MODE_CLEAR, 1'b0));
    load_channel(1'b0, 5);
    load_channel(1'b1, 2);
    query(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1);
    query(1'b1, 0, 32'hFFFF_FFFF, 32);
    set_regs(1, 32'hFFFF_FFFF);
    send_item(op_item(MODE_CLEAR, 1'b1));
    load_channel(1'b0, 70);
    load_channel(1'b1, 1);
    query(1'b0, 0, 32'hFFFF_FFFF, 1);
    query(1'b0, 100, 900, 32);
    query(1'b0, 1000, 40, 20);
    query(1'b1, 0, 4, 1);
  endtask

  // Random phases: mostly clean pyramids with random queries, some noise.
  task automatic test_random();
    in_item_t it;
    int unsigned bfr, dfr, phase;
    phase = 0;
    while (n_items < 380) begin
      phase++;
      if (phase % 4 == 1) begin
        bfr = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 16);
        dfr = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 400);
        set_regs(bfr, dfr);
      end
      if (n_items > 330) gaps_on = 1'b0;
      send_item(op_item(MODE_CLEAR, 1'($urandom_range(0, 1))));
      load_channel(1'b0, $urandom_range(1, 40));
      if ($urandom_range(0, 7) == 0) load_bucket(1'b1, 16'h0010, 16'hFFF0, 1'b0);
      load_channel(1'b1, $urandom_range(1, 40));
      repeat ($urandom_range(4, 10)) begin
        it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom});
        it.mode = ($urandom_range(0, 9) == 0) ? 2'($urandom) : MODE_QUERY;
        it.channel = 1'($urandom);
        it.query_count = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
        if ($urandom_range(0, 3) != 0 && doc_frames_r != 0)
          it.query_start = $urandom_range(0, doc_frames_r - 1);
        if (it.mode == MODE_CLEAR) it.mode = MODE_NONE;
        send_item(it);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      bucket_cnt[i] = 0;
      chan_ready[i] = 1'b0;
    end
    pyr_bad = 1'b0;
    base_frames_r = '0;
    doc_frames_r = '0;
    errors = 0; n_items = 0; n_results = 0; n_queries = 0; stall_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_extremes();
    test_random();
    drain();
    $display("Sent %0d items (%0d queries), checked %0d peak results.",
             n_items, n_queries, n_results);
    if (errors == 0 && peak_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d peaks missing", errors, peak_results_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
